[rtl/sctt_pkg.sv]
// Package for the striped chunk transfer tracker: transaction and command types,
// field codes and fixed constants of the transfer scheme.
// Depends on nothing; every other file of the block but sctt_fifo uses it.
`default_nettype none

package sctt_pkg;

    localparam int unsigned LANES       = 5;
    localparam int unsigned CHUNK_BYTES = 512;
    localparam int unsigned CHUNK_SHIFT = 9;
    localparam int unsigned MAX_CHUNKS  = 256;
    localparam int unsigned LANE_IDX_W  = $clog2(LANES);

    localparam logic [1:0] KIND_START = 2'd0;
    localparam logic [1:0] KIND_RESP  = 2'd1;
    localparam logic [1:0] KIND_ABORT = 2'd2;

    localparam logic OUT_REQUEST = 1'b0;
    localparam logic OUT_STATUS  = 1'b1;

    localparam logic [1:0] XFER_RECEIVING    = 2'd0;
    localparam logic [1:0] XFER_COMPLETE     = 2'd1;
    localparam logic [1:0] XFER_ERROR        = 2'd2;
    localparam logic [1:0] XFER_DISCONNECTED = 2'd3;

    localparam logic [1:0] RES_OK      = 2'd0;
    localparam logic [1:0] RES_FAIL    = 2'd1;
    localparam logic [1:0] RES_TIMEOUT = 2'd2;

    typedef struct packed {
        logic [1:0] kind;
        logic [2:0] lane_unit;
        logic       is_data_reply;
        logic       is_camera_function;
        logic       error_reply;
        logic       final_flag;
        logic [7:0] chunk_index;
        logic [7:0] word_count;
        logic       disconnected;
        logic       timed_out;
        logic [2:0] withdrawn;
    } t_in_item;

    typedef struct packed {
        logic        out_kind;
        logic [2:0]  req_lane;
        logic [7:0]  req_chunk;
        logic        req_first;
        logic [1:0]  xfer_state;
        logic [1:0]  result_code;
        logic [8:0]  chunks_done;
        logic [17:0] bytes_done;
        logic [17:0] image_bytes;
        logic [15:0] malformed_total;
        logic        last;
    } t_result;

    typedef enum logic [1:0] {
        OP_START,
        OP_RESP,
        OP_ABORT
    } t_op;

    typedef struct packed {
        t_op        op;
        logic [2:0] lane_unit;
        logic       lane_bad;
        logic       fmt_bad;
        logic       final_flag;
        logic [7:0] chunk_index;
        logic [9:0] payload;
        logic       disconnected;
        logic       timed_out;
        logic [2:0] withdrawn;
    } t_cmd;

endpackage

`default_nettype wire

[rtl/sctt_fifo.sv]
// Small first-in first-out queue of packed words with show-ahead read.
// Depends on nothing; used for the command queue and the result queue.
`default_nettype none

module sctt_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_wr,
    input  wire logic [WIDTH-1:0] i_wdata,
    output logic                  o_full,
    input  wire logic             i_rd,
    output logic [WIDTH-1:0]      o_rdata,
    output logic                  o_empty
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wptr;
    logic [PTR_W-1:0] r_rptr;
    logic [CNT_W-1:0] r_count;
    logic             wr_en;
    logic             rd_en;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign wr_en   = i_wr && !o_full;
    assign rd_en   = i_rd && !o_empty;
    assign o_rdata = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wptr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (wr_en) begin
                r_wptr <= (r_wptr == PTR_W'(DEPTH - 1)) ? '0 : r_wptr + PTR_W'(1);
            end
            if (rd_en) begin
                r_rptr <= (r_rptr == PTR_W'(DEPTH - 1)) ? '0 : r_rptr + PTR_W'(1);
            end
            if (wr_en && !rd_en) begin
                r_count <= r_count + CNT_W'(1);
            end else if (rd_en && !wr_en) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

endmodule

`default_nettype wire

[rtl/sctt_front.sv]
// Front end of the tracker: decodes accepted input transactions into commands
// and performs the checks that need no tracker state. Depends on sctt_pkg.
`default_nettype none

module sctt_front (
    input  wire logic              i_push,
    input  wire sctt_pkg::t_in_item i_item,
    input  wire logic              i_queue_full,
    output logic                   o_wr,
    output sctt_pkg::t_cmd         o_cmd
);

    import sctt_pkg::*;

    logic accept;
    logic known;

    assign accept = i_push && !i_queue_full;

    always_comb begin
        known        = 1'b1;
        o_cmd.op     = OP_START;
        unique case (i_item.kind)
            KIND_START: o_cmd.op = OP_START;
            KIND_RESP:  o_cmd.op = OP_RESP;
            KIND_ABORT: o_cmd.op = OP_ABORT;
            default:    known    = 1'b0;
        endcase

        o_cmd.lane_unit    = i_item.lane_unit;
        o_cmd.lane_bad     = (i_item.lane_unit == 3'd0) || (i_item.lane_unit > 3'(LANES));
        o_cmd.fmt_bad      = !i_item.is_data_reply || (i_item.word_count < 8'd3) ||
                             !i_item.is_camera_function || i_item.error_reply;
        o_cmd.final_flag   = i_item.final_flag;
        o_cmd.chunk_index  = i_item.chunk_index;
        o_cmd.payload      = {i_item.word_count - 8'd3, 2'b00};
        o_cmd.disconnected = i_item.disconnected;
        o_cmd.timed_out    = i_item.timed_out;
        o_cmd.withdrawn    = i_item.withdrawn;
    end

    // An unknown kind is taken from the channel and then dropped.
    assign o_wr = accept && known;

endmodule

`default_nettype wire

[rtl/sctt_back.sv]
// Back end of the tracker: holds the transfer state, executes queued commands
// and writes request and status transactions to the result queue.
// Depends on sctt_pkg.
`default_nettype none

module sctt_back (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_cfg_we,
    input  wire logic [8:0]      i_cfg_wdata,
    input  wire logic            i_cmd_empty,
    input  wire sctt_pkg::t_cmd  i_cmd,
    output logic                 o_cmd_pop,
    input  wire logic            i_res_full,
    output logic                 o_res_push,
    output sctt_pkg::t_result    o_res
);

    import sctt_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_APPLY,
        S_REQ,
        S_STAT
    } t_state;

    typedef enum logic [1:0] {
        SM_RECV,
        SM_ABORT,
        SM_DRAIN
    } t_stat_mode;

    t_state                r_state;
    t_stat_mode            r_mode;
    t_cmd                  r_cmd;
    logic [8:0]            r_chunk_total;
    logic [MAX_CHUNKS-1:0] r_map;
    logic [7:0]            r_lane_exp [LANES];
    logic [2:0]            r_pending;
    logic [8:0]            r_accepted;
    logic [17:0]           r_bytes;
    logic [17:0]           r_extent;
    logic [15:0]           r_malformed;
    logic                  r_active;
    logic                  r_done;
    logic                  r_term;
    logic                  r_cancel;
    logic                  r_disc;
    logic [1:0]            r_result;
    logic                  r_good;
    logic                  r_req_start;
    logic [2:0]            r_idx;
    logic [2:0]            r_cnt;
    logic [2:0]            r_req_lane;
    logic [7:0]            r_req_chunk;

    logic [8:0]            tot;
    logic [2:0]            start_cnt;
    logic [17:0]           cap;
    logic [17:0]           payload;
    logic [17:0]           chunk_off;
    logic [17:0]           chunk_end;
    logic [8:0]            chunk9;
    logic [8:0]            next_chunk;
    logic [LANE_IDX_W-1:0] lane_idx;
    logic                  exp_ok;
    logic                  good;
    logic                  fin_bad;
    logic                  want_req;
    logic                  drained;
    logic                  success;
    logic [1:0]            fin_result;
    logic [1:0]            fin_state;
    logic                  emit;

    always_comb begin
        tot        = (r_chunk_total > 9'(MAX_CHUNKS)) ? 9'(MAX_CHUNKS) : r_chunk_total;
        start_cnt  = (tot < 9'(LANES)) ? tot[2:0] : 3'(LANES);
        cap        = 18'(tot) << CHUNK_SHIFT;
        payload    = 18'(r_cmd.payload);
        chunk_off  = 18'(r_cmd.chunk_index) << CHUNK_SHIFT;
        chunk_end  = chunk_off + payload;
        chunk9     = {1'b0, r_cmd.chunk_index};
        next_chunk = chunk9 + 9'(LANES);
        lane_idx   = LANE_IDX_W'(r_cmd.lane_unit - 3'd1);
        exp_ok     = !r_cmd.lane_bad && (r_lane_exp[lane_idx] == r_cmd.chunk_index);
        good       = !r_cmd.fmt_bad && exp_ok && (chunk9 < tot) &&
                     (r_cmd.payload <= 10'(CHUNK_BYTES)) && (payload <= cap) &&
                     (chunk_off <= cap - payload) && !r_map[r_cmd.chunk_index];
        fin_bad    = r_cmd.final_flag && (chunk9 + 9'd1 != tot);
        want_req   = !fin_bad && (next_chunk < tot);

        drained    = !r_done && (r_pending == 3'd0);
        success    = !r_cancel && r_term && (r_accepted == tot);
        fin_result = success ? RES_OK : ((r_result == RES_OK) ? RES_FAIL : r_result);
        fin_state  = success ? XFER_COMPLETE : (r_disc ? XFER_DISCONNECTED : XFER_ERROR);
        emit       = drained || (r_mode != SM_DRAIN);
    end

    assign o_cmd_pop = (r_state == S_IDLE) && !i_cmd_empty;

    always_comb begin
        o_res      = '0;
        o_res_push = 1'b0;
        unique case (r_state)
            S_REQ: begin
                o_res_push     = !i_res_full;
                o_res.out_kind = OUT_REQUEST;
                if (r_req_start) begin
                    o_res.req_lane  = r_idx + 3'd1;
                    o_res.req_chunk = 8'(r_idx);
                    o_res.req_first = (r_idx == 3'd0);
                    o_res.last      = (r_idx == r_cnt - 3'd1);
                end else begin
                    o_res.req_lane  = r_req_lane;
                    o_res.req_chunk = r_req_chunk;
                end
            end
            S_STAT: begin
                o_res_push      = !i_res_full && emit;
                o_res.out_kind  = OUT_STATUS;
                o_res.result_code = drained ? fin_result : r_result;
                if (drained) begin
                    o_res.xfer_state = fin_state;
                end else if (r_mode == SM_RECV) begin
                    o_res.xfer_state = XFER_RECEIVING;
                end else begin
                    o_res.xfer_state = r_disc ? XFER_DISCONNECTED : XFER_ERROR;
                end
                o_res.chunks_done     = r_accepted;
                o_res.bytes_done      = r_bytes;
                o_res.image_bytes     = r_extent;
                o_res.malformed_total = r_malformed;
                o_res.last            = 1'b1;
            end
            default: begin
                o_res_push = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_mode        <= SM_RECV;
            r_chunk_total <= 9'd1;
            r_map         <= '0;
            for (int i = 0; i < LANES; i++) begin
                r_lane_exp[i] <= 8'd0;
            end
            r_pending     <= 3'd0;
            r_accepted    <= 9'd0;
            r_bytes       <= 18'd0;
            r_extent      <= 18'd0;
            r_malformed   <= 16'd0;
            r_active      <= 1'b0;
            r_done        <= 1'b0;
            r_term        <= 1'b0;
            r_cancel      <= 1'b0;
            r_disc        <= 1'b0;
            r_result      <= RES_OK;
            r_good        <= 1'b0;
            r_req_start   <= 1'b0;
            r_idx         <= 3'd0;
            r_cnt         <= 3'd0;
        end else begin
            if (i_cfg_we) begin
                r_chunk_total <= i_cfg_wdata;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (!i_cmd_empty) begin
                        r_cmd   <= i_cmd;
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    unique case (r_cmd.op)
                        OP_START: begin
                            r_map <= '0;
                            for (int i = 0; i < LANES; i++) begin
                                r_lane_exp[i] <= (3'(i) < start_cnt) ? 8'(i) : 8'd0;
                            end
                            r_accepted  <= 9'd0;
                            r_bytes     <= 18'd0;
                            r_extent    <= 18'd0;
                            r_active    <= 1'b1;
                            r_done      <= 1'b0;
                            r_term      <= 1'b0;
                            r_cancel    <= 1'b0;
                            r_disc      <= 1'b0;
                            r_result    <= RES_OK;
                            r_pending   <= start_cnt;
                            r_idx       <= 3'd0;
                            r_cnt       <= start_cnt;
                            r_req_start <= 1'b1;
                            r_mode      <= SM_ABORT;
                            r_state     <= (start_cnt == 3'd0) ? S_STAT : S_REQ;
                        end
                        OP_RESP: begin
                            if (!r_active || r_done) begin
                                r_state <= S_IDLE;
                            end else begin
                                if (r_pending != 3'd0) begin
                                    r_pending <= r_pending - 3'd1;
                                end
                                if (r_cancel) begin
                                    r_mode  <= SM_DRAIN;
                                    r_state <= S_STAT;
                                end else begin
                                    r_good  <= good;
                                    r_state <= S_APPLY;
                                end
                            end
                        end
                        OP_ABORT: begin
                            if (!r_active || r_done) begin
                                r_state <= S_IDLE;
                            end else begin
                                if (r_cmd.disconnected) begin
                                    r_disc <= 1'b1;
                                end
                                if (!r_cancel) begin
                                    r_cancel <= 1'b1;
                                    r_result <= r_cmd.timed_out ? RES_TIMEOUT : RES_FAIL;
                                end
                                r_pending <= (r_cmd.withdrawn >= r_pending) ? 3'd0 :
                                             r_pending - r_cmd.withdrawn;
                                r_mode    <= SM_ABORT;
                                r_state   <= S_STAT;
                            end
                        end
                        default: begin
                            r_state <= S_IDLE;
                        end
                    endcase
                end
                S_APPLY: begin
                    r_mode <= SM_RECV;
                    if (!r_good) begin
                        r_cancel <= 1'b1;
                        r_result <= RES_FAIL;
                        if (r_malformed != 16'hFFFF) begin
                            r_malformed <= r_malformed + 16'd1;
                        end
                        r_state <= S_STAT;
                    end else begin
                        r_map[r_cmd.chunk_index] <= 1'b1;
                        r_accepted <= r_accepted + 9'd1;
                        r_bytes    <= r_bytes + payload;
                        if (r_extent < chunk_end) begin
                            r_extent <= chunk_end;
                        end
                        if (r_cmd.final_flag) begin
                            if (fin_bad) begin
                                r_cancel <= 1'b1;
                                r_result <= RES_FAIL;
                                if (r_malformed != 16'hFFFF) begin
                                    r_malformed <= r_malformed + 16'd1;
                                end
                            end else begin
                                r_term <= 1'b1;
                            end
                        end
                        if (want_req) begin
                            r_lane_exp[lane_idx] <= next_chunk[7:0];
                            if (r_pending != 3'd7) begin
                                r_pending <= r_pending + 3'd1;
                            end
                            r_req_start <= 1'b0;
                            r_req_lane  <= r_cmd.lane_unit;
                            r_req_chunk <= next_chunk[7:0];
                            r_state     <= S_REQ;
                        end else begin
                            r_state <= S_STAT;
                        end
                    end
                end
                S_REQ: begin
                    if (!i_res_full) begin
                        if (!r_req_start) begin
                            r_state <= S_STAT;
                        end else if (r_idx == r_cnt - 3'd1) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_idx <= r_idx + 3'd1;
                        end
                    end
                end
                S_STAT: begin
                    if (!emit) begin
                        r_state <= S_IDLE;
                    end else if (!i_res_full) begin
                        if (drained) begin
                            r_result <= fin_result;
                            r_done   <= 1'b1;
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

[rtl/striped_chunk_transfer_tracker_core.sv]
// Top level of the striped chunk transfer tracker: front end, command queue,
// back end and result queue. Depends on sctt_pkg, sctt_front, sctt_fifo, sctt_back.
//
// Input transactions (start, lane response, abort) enter through push/full and
// results leave through empty/pop; both sides behave as queues. A start gives
// one request per lane in use, or one status when the chunk total is zero. On a
// live run an abort gives one status and a response an optional follow-on request
// and one status, or, once the run is cancelled, a status only when no request is
// pending; with no live run neither gives a result. The last result of an input
// transaction carries the last flag. The back end handles one command at a time
// and writes one result per cycle while the result queue has space: it takes a
// command, executes it, applies a response that is not cancelled, then writes its
// results. A first result passes the command queue, the command register and the
// execute (and apply) states before it enters the result queue. The command
// queue lets new transactions be taken while the back end is busy; full rises
// only when that queue is full. When the receiver stalls, results wait in the
// result queue and, once it fills, the back end holds its state until space
// appears. Reset clears the transfer state, empties both queues and sets
// chunk_total to 1; the chunk_total register is written through i_cfg_we and i_cfg_wdata.
`default_nettype none

module striped_chunk_transfer_tracker_core #(
    parameter int CMD_DEPTH = 2,
    parameter int RES_DEPTH = 4
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               push,
    output logic                    full,
    input  wire sctt_pkg::t_in_item i_item,
    output logic                    empty,
    input  wire logic               pop,
    output sctt_pkg::t_result       o_result,
    input  wire logic               i_cfg_we,
    input  wire logic [8:0]         i_cfg_wdata
);

    import sctt_pkg::*;

    logic    cmd_wr;
    t_cmd    cmd_in;
    logic    cmd_empty;
    logic    cmd_pop;
    t_cmd    cmd_out;
    logic    res_full;
    logic    res_push;
    t_result res_in;

    sctt_front u_front (
        .i_push       (push),
        .i_item       (i_item),
        .i_queue_full (full),
        .o_wr         (cmd_wr),
        .o_cmd        (cmd_in)
    );

    sctt_fifo #(
        .WIDTH ($bits(t_cmd)),
        .DEPTH (CMD_DEPTH)
    ) u_cmd_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (cmd_wr),
        .i_wdata (cmd_in),
        .o_full  (full),
        .i_rd    (cmd_pop),
        .o_rdata (cmd_out),
        .o_empty (cmd_empty)
    );

    sctt_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_cmd_empty (cmd_empty),
        .i_cmd       (cmd_out),
        .o_cmd_pop   (cmd_pop),
        .i_res_full  (res_full),
        .o_res_push  (res_push),
        .o_res       (res_in)
    );

    sctt_fifo #(
        .WIDTH ($bits(t_result)),
        .DEPTH (RES_DEPTH)
    ) u_res_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (res_push),
        .i_wdata (res_in),
        .o_full  (res_full),
        .i_rd    (pop),
        .o_rdata (o_result),
        .o_empty (empty)
    );

endmodule

`default_nettype wire

[rtl/sctt_checker.sv]
// Port-level checks on the result channel of the tracker, and the bind that
// attaches them to the top level. Depends on sctt_pkg and the top level.
`default_nettype none

module sctt_checker (
    input wire logic              i_clk,
    input wire logic              i_rst_n,
    input wire logic              i_empty,
    input wire logic              i_pop,
    input wire sctt_pkg::t_result i_result
);

    import sctt_pkg::*;

    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> i_empty)
        else $error("result queue not empty after reset");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!i_empty && !i_pop) |=> (!i_empty && $stable(i_result)))
        else $error("stalled result changed or vanished");

    a_status_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!i_empty && i_result.out_kind == OUT_STATUS) |-> i_result.last)
        else $error("status report not marked last");

    a_first_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!i_empty && i_result.out_kind == OUT_REQUEST && i_result.req_first) |->
        (i_result.req_lane == 3'd1 && i_result.req_chunk == 8'd0))
        else $error("start request not for chunk zero on the first lane");

    a_request_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!i_empty && i_result.out_kind == OUT_REQUEST) |->
        (i_result.req_lane != 3'd0 && i_result.xfer_state == XFER_RECEIVING &&
         i_result.chunks_done == 9'd0 && i_result.malformed_total == 16'd0))
        else $error("malformed chunk request");

endmodule

bind striped_chunk_transfer_tracker_core sctt_checker u_sctt_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .i_empty  (empty),
    .i_pop    (pop),
    .i_result (o_result)
);

`default_nettype wire
